// ----- hdl/usfp_pkg.sv -----
`timescale 1ns / 1ps

package usfp_pkg;

    localparam int BYTE_W = 8;
    localparam int IP_W   = 32;
    localparam int PORT_W = 16;
    localparam int KIND_W = 2;
    localparam int POS_W  = 9;
    localparam int CFG_W  = 3;

    typedef logic [BYTE_W-1:0] byte_t;
    typedef logic [IP_W-1:0]   ip_t;
    typedef logic [PORT_W-1:0] port_t;
    typedef logic [KIND_W-1:0] kind_t;
    typedef logic [POS_W-1:0]  pos_t;
    typedef logic [CFG_W-1:0]  cfg_idx_t;

    localparam kind_t KIND_DATA     = 2'd0;
    localparam kind_t KIND_END_OK   = 2'd1;
    localparam kind_t KIND_END_BAD  = 2'd2;

    localparam cfg_idx_t REG_START_MARKER = 3'd0;
    localparam cfg_idx_t REG_RECEIVE_CODE = 3'd1;
    localparam cfg_idx_t REG_SPACE_MARKER = 3'd2;
    localparam cfg_idx_t REG_STOP_MARKER  = 3'd3;
    localparam cfg_idx_t REG_MAX_PAYLOAD  = 3'd4;

    localparam byte_t MAX_PAYLOAD_RESET = 8'hFF;

    localparam pos_t POS_HUNT     = 9'd0;
    localparam pos_t POS_CODE     = 9'd1;
    localparam pos_t POS_SPACE0   = 9'd2;
    localparam pos_t POS_SRC_IP0  = 9'd3;
    localparam pos_t POS_SRC_IP1  = 9'd4;
    localparam pos_t POS_SRC_IP2  = 9'd5;
    localparam pos_t POS_SRC_IP3  = 9'd6;
    localparam pos_t POS_SPACE1   = 9'd7;
    localparam pos_t POS_SRC_PRT0 = 9'd8;
    localparam pos_t POS_SRC_PRT1 = 9'd9;
    localparam pos_t POS_SPACE2   = 9'd12;
    localparam pos_t POS_DST_IP0  = 9'd13;
    localparam pos_t POS_DST_IP1  = 9'd14;
    localparam pos_t POS_DST_IP2  = 9'd15;
    localparam pos_t POS_DST_IP3  = 9'd16;
    localparam pos_t POS_SPACE3   = 9'd17;
    localparam pos_t POS_DST_PRT0 = 9'd18;
    localparam pos_t POS_DST_PRT1 = 9'd19;
    localparam pos_t POS_SPACE4   = 9'd22;
    localparam pos_t POS_LENGTH   = 9'd23;
    localparam pos_t HEADER_BYTES = 9'd25;
    localparam pos_t POS_MAX      = 9'd280;

endpackage

// ----- hdl/usfp_byte_if.sv -----
`timescale 1ns / 1ps

interface usfp_byte_if;

    logic            valid;
    logic            ready;
    usfp_pkg::byte_t rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);

endinterface

// ----- hdl/usfp_result_if.sv -----
`timescale 1ns / 1ps

interface usfp_result_if;

    logic            valid;
    logic            ready;
    usfp_pkg::kind_t kind;
    usfp_pkg::byte_t data_byte;
    usfp_pkg::ip_t   src_ip;
    usfp_pkg::port_t src_port;
    usfp_pkg::ip_t   dst_ip;
    usfp_pkg::port_t dst_port;
    usfp_pkg::byte_t payload_len;
    logic            last;

    modport source (
        output valid, output kind, output data_byte, output src_ip, output src_port,
        output dst_ip, output dst_port, output payload_len, output last,
        input ready
    );
    modport sink (
        input valid, input kind, input data_byte, input src_ip, input src_port,
        input dst_ip, input dst_port, input payload_len, input last,
        output ready
    );

endinterface

// ----- hdl/udp_serial_frame_parser.sv -----
`timescale 1ns / 1ps

// Serial UDP receive frame parser. Each received byte is one transaction on rx; the block
// takes one byte per clock and answers with at most one transaction on res: a payload byte
// (kind data) or the frame end (kind end ok or end bad stop, last high). Every result carries
// the captured addresses, ports and the delivered length min(length byte, max_payload).
// A byte passes an input register and one compare/capture step into the result register.
// With res ready one byte per clock passes. While a result waits on res the input register
// can still take one byte if it is empty, then rx stalls until res is taken. Header mismatch
// drops the byte and restarts the hunt.
// Write the configuration registers only while no frame is in progress.

module udp_serial_frame_parser (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  usfp_pkg::cfg_idx_t       cfg_index,
    input  usfp_pkg::byte_t          cfg_data,
    usfp_byte_if.sink                rx,
    usfp_result_if.source            res
);

    usfp_pkg::byte_t start_marker_reg;
    usfp_pkg::byte_t receive_code_reg;
    usfp_pkg::byte_t space_marker_reg;
    usfp_pkg::byte_t stop_marker_reg;
    usfp_pkg::byte_t max_payload_reg;

    logic            in_valid_reg;
    usfp_pkg::byte_t in_byte_reg;

    usfp_pkg::pos_t  pos_reg,      pos_next;
    usfp_pkg::ip_t   src_ip_reg,   src_ip_next;
    usfp_pkg::port_t src_port_reg, src_port_next;
    usfp_pkg::ip_t   dst_ip_reg,   dst_ip_next;
    usfp_pkg::port_t dst_port_reg, dst_port_next;
    usfp_pkg::byte_t length_reg,   length_next;

    logic            out_valid_reg;
    usfp_pkg::kind_t out_kind_reg,  out_kind_next;
    usfp_pkg::byte_t out_data_reg,  out_data_next;
    usfp_pkg::byte_t out_len_reg;
    logic            out_last_reg,  out_last_next;
    logic            emit;

    logic            advance;
    logic            in_payload;
    logic            more_payload;
    usfp_pkg::pos_t  idx_full;
    usfp_pkg::byte_t idx;
    usfp_pkg::byte_t deliver_len;

    assign advance      = in_valid_reg && (!out_valid_reg || res.ready);
    assign rx.ready     = !in_valid_reg || advance;
    assign in_payload   = pos_reg >= usfp_pkg::HEADER_BYTES;
    assign idx_full     = pos_reg - usfp_pkg::HEADER_BYTES;
    assign idx          = idx_full[usfp_pkg::BYTE_W-1:0];
    assign more_payload = idx < length_reg;
    assign deliver_len  = (length_reg < max_payload_reg) ? length_reg : max_payload_reg;

    always_comb
    begin
        pos_next      = pos_reg;
        src_ip_next   = src_ip_reg;
        src_port_next = src_port_reg;
        dst_ip_next   = dst_ip_reg;
        dst_port_next = dst_port_reg;
        length_next   = length_reg;
        emit          = 1'b0;
        out_kind_next = usfp_pkg::KIND_DATA;
        out_data_next = '0;
        out_last_next = 1'b0;
        if (in_payload)
        begin
            if (more_payload)
            begin
                pos_next      = pos_reg + 9'd1;
                emit          = idx < max_payload_reg;
                out_data_next = in_byte_reg;
            end
            else
            begin
                pos_next      = usfp_pkg::POS_HUNT;
                emit          = 1'b1;
                out_last_next = 1'b1;
                out_kind_next = (in_byte_reg == stop_marker_reg) ? usfp_pkg::KIND_END_OK
                                                                 : usfp_pkg::KIND_END_BAD;
            end
        end
        else
        begin
            pos_next = pos_reg + 9'd1;
            unique case (pos_reg)
                usfp_pkg::POS_HUNT:
                    if (in_byte_reg != start_marker_reg) pos_next = usfp_pkg::POS_HUNT;
                usfp_pkg::POS_CODE:
                    if (in_byte_reg != receive_code_reg) pos_next = usfp_pkg::POS_HUNT;
                usfp_pkg::POS_SPACE0, usfp_pkg::POS_SPACE1, usfp_pkg::POS_SPACE2,
                usfp_pkg::POS_SPACE3, usfp_pkg::POS_SPACE4:
                    if (in_byte_reg != space_marker_reg) pos_next = usfp_pkg::POS_HUNT;
                usfp_pkg::POS_SRC_IP0:  src_ip_next[7:0]    = in_byte_reg;
                usfp_pkg::POS_SRC_IP1:  src_ip_next[15:8]   = in_byte_reg;
                usfp_pkg::POS_SRC_IP2:  src_ip_next[23:16]  = in_byte_reg;
                usfp_pkg::POS_SRC_IP3:  src_ip_next[31:24]  = in_byte_reg;
                usfp_pkg::POS_SRC_PRT0: src_port_next[7:0]  = in_byte_reg;
                usfp_pkg::POS_SRC_PRT1: src_port_next[15:8] = in_byte_reg;
                usfp_pkg::POS_DST_IP0:  dst_ip_next[7:0]    = in_byte_reg;
                usfp_pkg::POS_DST_IP1:  dst_ip_next[15:8]   = in_byte_reg;
                usfp_pkg::POS_DST_IP2:  dst_ip_next[23:16]  = in_byte_reg;
                usfp_pkg::POS_DST_IP3:  dst_ip_next[31:24]  = in_byte_reg;
                usfp_pkg::POS_DST_PRT0: dst_port_next[7:0]  = in_byte_reg;
                usfp_pkg::POS_DST_PRT1: dst_port_next[15:8] = in_byte_reg;
                usfp_pkg::POS_LENGTH:   length_next         = in_byte_reg;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_marker_reg <= '0;
            receive_code_reg <= '0;
            space_marker_reg <= '0;
            stop_marker_reg  <= '0;
            max_payload_reg  <= usfp_pkg::MAX_PAYLOAD_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                usfp_pkg::REG_START_MARKER: start_marker_reg <= cfg_data;
                usfp_pkg::REG_RECEIVE_CODE: receive_code_reg <= cfg_data;
                usfp_pkg::REG_SPACE_MARKER: space_marker_reg <= cfg_data;
                usfp_pkg::REG_STOP_MARKER:  stop_marker_reg  <= cfg_data;
                usfp_pkg::REG_MAX_PAYLOAD:  max_payload_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            pos_reg       <= usfp_pkg::POS_HUNT;
            src_ip_reg    <= '0;
            src_port_reg  <= '0;
            dst_ip_reg    <= '0;
            dst_port_reg  <= '0;
            length_reg    <= '0;
        end
        else
        begin
            if (rx.ready)
            begin
                in_valid_reg <= rx.valid;
            end
            if (advance)
            begin
                out_valid_reg <= emit;
                pos_reg       <= pos_next;
                src_ip_reg    <= src_ip_next;
                src_port_reg  <= src_port_next;
                dst_ip_reg    <= dst_ip_next;
                dst_port_reg  <= dst_port_next;
                length_reg    <= length_next;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx.valid && rx.ready)
        begin
            in_byte_reg <= rx.rx_byte;
        end
        if (advance && emit)
        begin
            out_kind_reg <= out_kind_next;
            out_data_reg <= out_data_next;
            out_last_reg <= out_last_next;
            out_len_reg  <= deliver_len;
        end
    end

    assign res.valid       = out_valid_reg;
    assign res.kind        = out_kind_reg;
    assign res.data_byte   = out_data_reg;
    assign res.src_ip      = src_ip_reg;
    assign res.src_port    = src_port_reg;
    assign res.dst_ip      = dst_ip_reg;
    assign res.dst_port    = dst_port_reg;
    assign res.payload_len = out_len_reg;
    assign res.last        = out_last_reg;

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= usfp_pkg::POS_MAX)
        else $error("frame position out of range");

    a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_last_reg == (out_kind_reg != usfp_pkg::KIND_DATA)))
        else $error("last flag disagrees with result kind");

    a_end_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_last_reg) |-> (out_data_reg == '0))
        else $error("frame end carries data");

    a_end_rehunt: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_payload && !more_payload)
        |=> (pos_reg == usfp_pkg::POS_HUNT && out_valid_reg))
        else $error("frame end did not restart hunt");

endmodule
